FILE: design/nmea_position_extractor_top_defines.svh
// assertion macros shared by the design files
`ifndef NMEA_POSITION_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_POSITION_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTH

// checked only outside reset
`define NPE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every edge, reset included
`define NPE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define NPE_ASSERT(label, clk, rstn, prop, msg)
`define NPE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: design/npe_pkg.sv
package npe_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_E      = 8'h45;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    localparam int HDR_LEN = 4;
    localparam int HDR_W   = $clog2(HDR_LEN);
    localparam logic [BYTE_W-1:0] HDR_CHARS [HDR_LEN] = '{CH_DOLLAR, CH_G, CH_N, CH_R};
    localparam logic [HDR_W-1:0]  HDR_LAST  = HDR_W'(HDR_LEN - 1);

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;
    localparam logic [CNT_W-1:0] COMMAS_OK   = 4'd13;
    localparam logic [CNT_W-1:0] LAT_LEN     = 4'd10;
    localparam logic [CNT_W-1:0] LON_LEN     = 4'd11;
    localparam logic [CNT_W-1:0] LAT_DEG_LEN = 4'd2;
    localparam logic [CNT_W-1:0] LON_DEG_LEN = 4'd3;
    localparam logic [CNT_W-1:0] LAT_POINT   = 4'd4;
    localparam logic [CNT_W-1:0] LON_POINT   = 4'd5;
    localparam logic [CNT_W-1:0] HEMI_LEN    = 4'd1;

    // field number, counted in commas seen so far
    localparam logic [CNT_W-1:0] FLD_LAT = 4'd3;
    localparam logic [CNT_W-1:0] FLD_NS  = 4'd4;
    localparam logic [CNT_W-1:0] FLD_LON = 4'd5;
    localparam logic [CNT_W-1:0] FLD_EW  = 4'd6;

    localparam int DIGIT_W   = 4;
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int MIN_W     = 24;
    localparam int LAT_E7_W  = 31;
    localparam int LON_E7_W  = 35;

    localparam int E7_W = 24;
    localparam logic [E7_W-1:0] E7 = 24'd10000000;

    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2^27
    localparam int X5_W       = MIN_W + 3;
    localparam int RECIP_W    = 26;
    localparam int DIV3_SHIFT = 27;
    localparam logic [RECIP_W-1:0] DIV3_RECIP = 26'd44739243;
    localparam int PROD_W = X5_W + RECIP_W;
    localparam int FRAC_W = PROD_W - DIV3_SHIFT;

    localparam int RES_BITS = 3 + LAT_E7_W + LON_E7_W;
    localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - RES_BITS;

    typedef struct packed {
        logic                 status;
        logic                 lat_valid;
        logic                 lat_neg;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic                 lon_valid;
        logic                 lon_neg;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
    } npe_fix_t;

    typedef struct packed {
        logic status;
        logic lat_valid;
        logic lat_neg;
        logic lon_valid;
        logic lon_neg;
    } npe_flags_t;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - CH_ZERO;
        return (b >= CH_ZERO && b <= CH_NINE) ? d[DIGIT_W-1:0] : '0;
    endfunction

endpackage

FILE: design/npe_parser.sv
`include "nmea_position_extractor_top_defines.svh"

module npe_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [npe_pkg::BYTE_W-1:0]   s_tdata,
    output npe_pkg::npe_fix_t            fix,
    output logic                         fix_valid,
    input  logic                         fix_ready
);
    import npe_pkg::*;

    logic                  accept;
    logic [DIGIT_W-1:0]    digit;
    logic                  hdr_done;
    logic                  frame_clear;
    logic                  emit;
    logic                  commas_ok;

    logic [HDR_W-1:0]      hdr_match_reg, hdr_match_next;
    logic                  in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]      comma_count_reg, comma_count_next;
    logic [CNT_W-1:0]      field_length_reg, field_length_next;
    logic [LAT_DEG_W-1:0]  lat_deg_reg, lat_deg_next;
    logic [MIN_W-1:0]      lat_min_reg, lat_min_next;
    logic [1:0]            lat_ok_reg, lat_ok_next;
    logic                  lat_north_reg, lat_north_next;
    logic [LON_DEG_W-1:0]  lon_deg_reg, lon_deg_next;
    logic [MIN_W-1:0]      lon_min_reg, lon_min_next;
    logic [1:0]            lon_ok_reg, lon_ok_next;
    logic                  lon_east_reg, lon_east_next;
    npe_fix_t              fix_reg, fix_next;
    logic                  fix_vld_reg, fix_vld_next;

    assign s_tready  = !fix_vld_reg || fix_ready;
    assign accept    = s_tvalid && s_tready;
    assign digit     = digit_of(s_tdata);
    assign commas_ok = (comma_count_reg == COMMAS_OK);
    assign fix       = fix_reg;
    assign fix_valid = fix_vld_reg;

    always_comb begin
        hdr_match_next    = hdr_match_reg;
        in_frame_next     = in_frame_reg;
        comma_count_next  = comma_count_reg;
        field_length_next = field_length_reg;
        lat_deg_next      = lat_deg_reg;
        lat_min_next      = lat_min_reg;
        lat_ok_next       = lat_ok_reg;
        lat_north_next    = lat_north_reg;
        lon_deg_next      = lon_deg_reg;
        lon_min_next      = lon_min_reg;
        lon_ok_next       = lon_ok_reg;
        lon_east_next     = lon_east_reg;
        hdr_done          = 1'b0;
        frame_clear       = 1'b0;
        emit              = 1'b0;

        if (accept) begin
            if (s_tdata == HDR_CHARS[hdr_match_reg]) begin
                if (hdr_match_reg == HDR_LAST) begin
                    hdr_match_next = '0;
                    in_frame_next  = 1'b1;
                    hdr_done       = 1'b1;
                    frame_clear    = 1'b1;
                end else begin
                    hdr_match_next = hdr_match_reg + HDR_W'(1);
                end
            end else begin
                hdr_match_next = (s_tdata == CH_DOLLAR) ? HDR_W'(1) : '0;
            end

            if (!hdr_done && in_frame_reg) begin
                priority if (s_tdata == CH_STAR) begin
                    emit          = 1'b1;
                    in_frame_next = 1'b0;
                    frame_clear   = 1'b1;
                end else if (s_tdata == CH_COMMA) begin
                    if (comma_count_reg == FLD_LAT && field_length_reg == LAT_LEN)
                        lat_ok_next[0] = 1'b1;
                    if (comma_count_reg == FLD_NS && field_length_reg == HEMI_LEN)
                        lat_ok_next[1] = 1'b1;
                    if (comma_count_reg == FLD_LON && field_length_reg == LON_LEN)
                        lon_ok_next[0] = 1'b1;
                    if (comma_count_reg == FLD_EW && field_length_reg == HEMI_LEN)
                        lon_ok_next[1] = 1'b1;
                    if (comma_count_reg != CNT_MAX)
                        comma_count_next = comma_count_reg + CNT_W'(1);
                    field_length_next = '0;
                end else begin
                    // digit accumulation as x*10 + d, the point position skipped
                    priority if (comma_count_reg == FLD_LAT) begin
                        if (field_length_reg < LAT_DEG_LEN)
                            lat_deg_next = (lat_deg_reg << 3) + (lat_deg_reg << 1)
                                         + LAT_DEG_W'(digit);
                        else if (field_length_reg < LAT_LEN
                                 && field_length_reg != LAT_POINT)
                            lat_min_next = (lat_min_reg << 3) + (lat_min_reg << 1)
                                         + MIN_W'(digit);
                    end else if (comma_count_reg == FLD_NS) begin
                        if (field_length_reg == '0)
                            lat_north_next = (s_tdata == CH_N);
                    end else if (comma_count_reg == FLD_LON) begin
                        if (field_length_reg < LON_DEG_LEN)
                            lon_deg_next = (lon_deg_reg << 3) + (lon_deg_reg << 1)
                                         + LON_DEG_W'(digit);
                        else if (field_length_reg < LON_LEN
                                 && field_length_reg != LON_POINT)
                            lon_min_next = (lon_min_reg << 3) + (lon_min_reg << 1)
                                         + MIN_W'(digit);
                    end else if (comma_count_reg == FLD_EW) begin
                        if (field_length_reg == '0)
                            lon_east_next = (s_tdata == CH_E);
                    end else begin
                        lat_deg_next = lat_deg_reg;
                    end
                    if (field_length_reg != CNT_MAX)
                        field_length_next = field_length_reg + CNT_W'(1);
                end
            end
        end

        if (frame_clear) begin
            comma_count_next  = '0;
            field_length_next = '0;
            lat_deg_next      = '0;
            lat_min_next      = '0;
            lat_ok_next       = '0;
            lat_north_next    = 1'b0;
            lon_deg_next      = '0;
            lon_min_next      = '0;
            lon_ok_next       = '0;
            lon_east_next     = 1'b0;
        end
    end

    always_comb begin
        fix_next           = fix_reg;
        fix_vld_next       = fix_vld_reg && !fix_ready;
        if (emit) begin
            fix_vld_next       = 1'b1;
            fix_next.status    = !commas_ok;
            fix_next.lat_valid = commas_ok && (lat_ok_reg == 2'b11);
            fix_next.lat_neg   = !lat_north_reg;
            fix_next.lat_deg   = lat_deg_reg;
            fix_next.lat_min   = lat_min_reg;
            fix_next.lon_valid = commas_ok && (lon_ok_reg == 2'b11);
            fix_next.lon_neg   = !lon_east_reg;
            fix_next.lon_deg   = lon_deg_reg;
            fix_next.lon_min   = lon_min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_match_reg    <= '0;
            in_frame_reg     <= 1'b0;
            comma_count_reg  <= '0;
            field_length_reg <= '0;
            lat_ok_reg       <= '0;
            lon_ok_reg       <= '0;
            fix_vld_reg      <= 1'b0;
        end else begin
            hdr_match_reg    <= hdr_match_next;
            in_frame_reg     <= in_frame_next;
            comma_count_reg  <= comma_count_next;
            field_length_reg <= field_length_next;
            lat_ok_reg       <= lat_ok_next;
            lon_ok_reg       <= lon_ok_next;
            fix_vld_reg      <= fix_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        lat_deg_reg    <= lat_deg_next;
        lat_min_reg    <= lat_min_next;
        lat_north_reg  <= lat_north_next;
        lon_deg_reg    <= lon_deg_next;
        lon_min_reg    <= lon_min_next;
        lon_east_reg   <= lon_east_next;
        fix_reg        <= fix_next;
    end

    `NPE_ASSERT(a_fix_from_transfer, aclk, aresetn, $rose(fix_vld_reg) |-> $past(accept), "fix captured without a byte transfer")
    `NPE_ASSERT(a_fix_closes_frame, aclk, aresetn, $rose(fix_vld_reg) |-> !in_frame_reg, "frame still open after a result")
    `NPE_ASSERT(a_frame_starts_clean, aclk, aresetn, $rose(in_frame_reg) |-> (comma_count_reg == '0) && (field_length_reg == '0) && (lat_ok_reg == '0) && (lon_ok_reg == '0), "new frame not cleared")

endmodule

FILE: design/npe_scale.sv
`include "nmea_position_extractor_top_defines.svh"

module npe_scale (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  npe_pkg::npe_fix_t           fix,
    input  logic                        fix_valid,
    output logic                        fix_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [npe_pkg::OUT_W-1:0]   m_tdata
);
    import npe_pkg::*;

    logic                  rd_b, rd_c, rd_d;
    logic [X5_W-1:0]       lat_x5, lon_x5;
    logic [PROD_W-1:0]     lat_prod, lon_prod;
    logic [LAT_E7_W-1:0]   lat_whole;
    logic [LON_E7_W-1:0]   lon_whole;
    logic [LAT_E7_W-1:0]   lat_signed;
    logic [LON_E7_W-1:0]   lon_signed;

    logic                  b_vld_reg, b_vld_next;
    npe_flags_t            b_flags_reg;
    logic [LAT_E7_W-1:0]   b_lat_whole_reg;
    logic [FRAC_W-1:0]     b_lat_frac_reg;
    logic [LON_E7_W-1:0]   b_lon_whole_reg;
    logic [FRAC_W-1:0]     b_lon_frac_reg;

    logic                  c_vld_reg, c_vld_next;
    npe_flags_t            c_flags_reg;
    logic [LAT_E7_W-1:0]   c_lat_mag_reg;
    logic [LON_E7_W-1:0]   c_lon_mag_reg;

    logic                  d_vld_reg, d_vld_next;
    logic                  d_status_reg;
    logic                  d_lat_valid_reg;
    logic [LAT_E7_W-1:0]   d_lat_reg;
    logic                  d_lon_valid_reg;
    logic [LON_E7_W-1:0]   d_lon_reg;

    // each stage moves when the one after it is empty or moving
    assign rd_d      = !d_vld_reg || m_tready;
    assign rd_c      = !c_vld_reg || rd_d;
    assign rd_b      = !b_vld_reg || rd_c;
    assign fix_ready = rd_b;

    assign b_vld_next = rd_b ? fix_valid : b_vld_reg;
    assign c_vld_next = rd_c ? b_vld_reg : c_vld_reg;
    assign d_vld_next = rd_d ? c_vld_reg : d_vld_reg;

    // minutes in 1e-5 times 5/3 gives 1e-7 degree
    assign lat_x5    = X5_W'({fix.lat_min, 2'b00}) + X5_W'(fix.lat_min);
    assign lon_x5    = X5_W'({fix.lon_min, 2'b00}) + X5_W'(fix.lon_min);
    assign lat_prod  = PROD_W'(lat_x5) * PROD_W'(DIV3_RECIP);
    assign lon_prod  = PROD_W'(lon_x5) * PROD_W'(DIV3_RECIP);
    assign lat_whole = LAT_E7_W'(fix.lat_deg) * LAT_E7_W'(E7);
    assign lon_whole = LON_E7_W'(fix.lon_deg) * LON_E7_W'(E7);

    assign lat_signed = c_flags_reg.lat_neg ? (~c_lat_mag_reg + LAT_E7_W'(1)) : c_lat_mag_reg;
    assign lon_signed = c_flags_reg.lon_neg ? (~c_lon_mag_reg + LON_E7_W'(1)) : c_lon_mag_reg;

    assign m_tvalid = d_vld_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, d_lon_reg, d_lon_valid_reg, d_lat_reg,
                       d_lat_valid_reg, d_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
            d_vld_reg <= d_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_b) begin
            b_flags_reg.status    <= fix.status;
            b_flags_reg.lat_valid <= fix.lat_valid;
            b_flags_reg.lat_neg   <= fix.lat_neg;
            b_flags_reg.lon_valid <= fix.lon_valid;
            b_flags_reg.lon_neg   <= fix.lon_neg;
            b_lat_whole_reg       <= lat_whole;
            b_lat_frac_reg        <= lat_prod[PROD_W-1:DIV3_SHIFT];
            b_lon_whole_reg       <= lon_whole;
            b_lon_frac_reg        <= lon_prod[PROD_W-1:DIV3_SHIFT];
        end
        if (rd_c) begin
            c_flags_reg   <= b_flags_reg;
            c_lat_mag_reg <= b_lat_whole_reg + LAT_E7_W'(b_lat_frac_reg);
            c_lon_mag_reg <= b_lon_whole_reg + LON_E7_W'(b_lon_frac_reg);
        end
        if (rd_d) begin
            d_status_reg    <= c_flags_reg.status;
            d_lat_valid_reg <= c_flags_reg.lat_valid;
            d_lat_reg       <= c_flags_reg.lat_valid ? lat_signed : '0;
            d_lon_valid_reg <= c_flags_reg.lon_valid;
            d_lon_reg       <= c_flags_reg.lon_valid ? lon_signed : '0;
        end
    end

    `NPE_ASSERT(a_err_no_coord, aclk, aresetn, d_vld_reg && d_status_reg |-> !d_lat_valid_reg && !d_lon_valid_reg, "error result carries a valid coordinate")
    `NPE_ASSERT(a_invalid_is_zero, aclk, aresetn, d_vld_reg |-> (d_lat_valid_reg || d_lat_reg == '0) && (d_lon_valid_reg || d_lon_reg == '0), "invalid coordinate not zero")
    `NPE_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !b_vld_reg && !c_vld_reg && !d_vld_reg, "pipeline not empty after reset")

endmodule

FILE: design/nmea_position_extractor_top.sv
// channel   dir  width  payload
// s_axis    in   8      tdata: byte_in[7:0]
// m_axis    out  72     tdata: status, lat_valid, latitude_e7, lon_valid, longitude_e7
//
// one byte transfer per cycle; s_tready stays high unless a finished result
// is blocked and the capture register behind it is full
// after the '*' transfer a result is registered in turn: capture, multiply, add, sign
// aresetn is synchronous; it drops the partial header, the open frame and all
// results still in the pipeline
module nmea_position_extractor_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [npe_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] status, [1] lat_valid, [32:2] latitude_e7, [33] lon_valid,
    // [68:34] longitude_e7, [71:69] zero
    output logic [npe_pkg::OUT_W-1:0]   m_tdata
);
    import npe_pkg::*;

    npe_fix_t fix;
    logic     fix_valid;
    logic     fix_ready;

    npe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fix       (fix),
        .fix_valid (fix_valid),
        .fix_ready (fix_ready)
    );

    npe_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fix       (fix),
        .fix_valid (fix_valid),
        .fix_ready (fix_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/nmea_position_extractor_checker.sv
`timescale 1ns / 100ps

module nmea_position_extractor_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [npe_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_in
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    // [0] status, [1] lat_valid, [32:2] latitude_e7, [33] lon_valid,
    // [68:34] longitude_e7, [71:69] zero
    input  logic [npe_pkg::OUT_W-1:0]  m_tdata,
    output int                         fail_count,
    output int                         fixes_pending,
    output int                         fixes_predicted
);
    import npe_pkg::*;

    // "$GNR", first character in the low byte
    localparam logic [31:0] SYNC_WORD = {CH_R, CH_N, CH_G, CH_DOLLAR};

    typedef struct packed {
        logic                status;
        logic                lat_valid;
        logic [LAT_E7_W-1:0] lat_e7;
        logic                lon_valid;
        logic [LON_E7_W-1:0] lon_e7;
    } fix_t;

    fix_t expected_fixes[$];

    logic [1:0]           sync_cnt;
    logic                 framed;
    logic [CNT_W-1:0]     commas;
    logic [CNT_W-1:0]     flen;
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic [1:0]           lat_ok;
    logic                 lat_north;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [MIN_W-1:0]     lon_min;
    logic [1:0]           lon_ok;
    logic                 lon_east;

    function automatic void clear_fields();
        commas    = '0;
        flen      = '0;
        lat_deg   = '0;
        lat_min   = '0;
        lat_ok    = '0;
        lat_north = 1'b0;
        lon_deg   = '0;
        lon_min   = '0;
        lon_ok    = '0;
        lon_east  = 1'b0;
    endfunction

    // degrees * 1e7 + minutes(1e-5) * 5 / 3, two's complement when negative
    function automatic logic [63:0] scaled_e7(input logic [LON_DEG_W-1:0] deg,
                                              input logic [MIN_W-1:0]     minutes,
                                              input logic                 positive);
        logic [63:0] mag;
        mag = 64'(deg) * 64'd10000000 + 64'(minutes) * 64'd5 / 64'd3;
        return positive ? mag : 64'd0 - mag;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic parse_char(input logic [BYTE_W-1:0] b);
        logic [DIGIT_W-1:0] d;
        logic               header_done;
        logic               ok;
        fix_t               fix;
        header_done = 1'b0;
        if (b == SYNC_WORD[8*sync_cnt +: 8]) begin
            if (sync_cnt == 2'd3) begin
                sync_cnt    = 2'd0;
                framed      = 1'b1;
                header_done = 1'b1;
                clear_fields();
            end else begin
                sync_cnt = sync_cnt + 2'd1;
            end
        end else begin
            sync_cnt = (b == CH_DOLLAR) ? 2'd1 : 2'd0;
        end
        d = (b >= CH_ZERO && b <= CH_NINE) ? DIGIT_W'(b - CH_ZERO) : '0;
        if (framed && !header_done) begin
            if (b == CH_STAR) begin
                ok            = (commas == COMMAS_OK);
                fix.status    = !ok;
                fix.lat_valid = ok && (lat_ok == 2'b11);
                fix.lon_valid = ok && (lon_ok == 2'b11);
                fix.lat_e7    = fix.lat_valid ?
                                LAT_E7_W'(scaled_e7(lat_deg, lat_min, lat_north)) : '0;
                fix.lon_e7    = fix.lon_valid ?
                                LON_E7_W'(scaled_e7(lon_deg, lon_min, lon_east)) : '0;
                expected_fixes.push_back(fix);
                fixes_predicted++;
                framed = 1'b0;
                clear_fields();
            end else if (b == CH_COMMA) begin
                if (commas == FLD_LAT && flen == LAT_LEN)  lat_ok[0] = 1'b1;
                if (commas == FLD_NS  && flen == HEMI_LEN) lat_ok[1] = 1'b1;
                if (commas == FLD_LON && flen == LON_LEN)  lon_ok[0] = 1'b1;
                if (commas == FLD_EW  && flen == HEMI_LEN) lon_ok[1] = 1'b1;
                if (commas != CNT_MAX) commas = commas + 1'b1;
                flen = '0;
            end else begin
                case (commas)
                    FLD_LAT: begin
                        if (flen < LAT_DEG_LEN)
                            lat_deg = LAT_DEG_W'(lat_deg * 10 + d);
                        else if (flen < LAT_LEN && flen != LAT_POINT)
                            lat_min = MIN_W'(lat_min * 10 + d);
                    end
                    FLD_NS: if (flen == '0) lat_north = (b == CH_N);
                    FLD_LON: begin
                        if (flen < LON_DEG_LEN)
                            lon_deg = LON_DEG_W'(lon_deg * 10 + d);
                        else if (flen < LON_LEN && flen != LON_POINT)
                            lon_min = MIN_W'(lon_min * 10 + d);
                    end
                    FLD_EW: if (flen == '0) lon_east = (b == CH_E);
                    default: ;
                endcase
                if (flen != CNT_MAX) flen = flen + 1'b1;
            end
        end
    endtask

    task automatic check_fix(input logic [OUT_W-1:0] data);
        fix_t                want;
        logic [LAT_E7_W-1:0] got_lat;
        logic [LON_E7_W-1:0] got_lon;
        got_lat = data[2 +: LAT_E7_W];
        got_lon = data[3 + LAT_E7_W +: LON_E7_W];
        if (expected_fixes.size() == 0) begin
            report_mismatch("result with none pending", 1, 0);
        end else begin
            want = expected_fixes.pop_front();
            if (data[0] !== want.status)
                report_mismatch("status", data[0], want.status);
            if (data[1] !== want.lat_valid)
                report_mismatch("lat_valid", data[1], want.lat_valid);
            if (got_lat !== want.lat_e7)
                report_mismatch("latitude_e7", $signed(got_lat), $signed(want.lat_e7));
            if (data[2 + LAT_E7_W] !== want.lon_valid)
                report_mismatch("lon_valid", data[2 + LAT_E7_W], want.lon_valid);
            if (got_lon !== want.lon_e7)
                report_mismatch("longitude_e7", $signed(got_lon), $signed(want.lon_e7));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_fixes.delete();
            sync_cnt = 2'd0;
            framed   = 1'b0;
            clear_fields();
        end else begin
            // a result can never come from the byte taken at the same edge
            if (m_tvalid && m_tready) check_fix(m_tdata);
            if (s_tvalid && s_tready) parse_char(s_tdata);
        end
        fixes_pending = expected_fixes.size();
    end

endmodule

FILE: tb/nmea_position_extractor_top_tb.sv
`timescale 1ns / 100ps

module nmea_position_extractor_top_tb;
    import npe_pkg::*;

    localparam int ITEM_TARGET  = 1750;
    localparam int CALM_TAIL    = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_W     = 8'h57;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int fail_count;
    int fixes_pending;
    int fixes_predicted;

    bit src_idle   = 1'b0;
    bit snk_idle   = 1'b0;
    bit hold_start = 1'b0;
    int bytes_sent = 0;
    int cycle_cnt;
    logic [BYTE_W-1:0] line_q[$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    nmea_position_extractor_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nmea_position_extractor_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .fixes_pending   (fixes_pending),
        .fixes_predicted (fixes_predicted)
    );

    // one byte transfer, starting and ending at a falling edge
    task automatic put_byte(input logic [BYTE_W-1:0] b);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_q[i]) put_byte(line_q[i]);
        line_q.delete();
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    // any byte that does not change the field structure
    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255));
        while (b == CH_COMMA || b == CH_STAR);
        return b;
    endfunction

    task automatic add_filler(input int n);
        repeat (n) line_q.push_back(filler_byte());
    endtask

    task automatic add_coord(input int len, input int point, input bit noisy);
        int i;
        for (i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                line_q.push_back(filler_byte());
            else if (i == point)
                line_q.push_back(CH_POINT);
            else
                line_q.push_back(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic add_hemi(input int len, input logic [BYTE_W-1:0] pos_ch,
                            input logic [BYTE_W-1:0] neg_ch);
        int r;
        repeat (len) begin
            r = $urandom_range(0, 9);
            if (r < 5)      line_q.push_back(pos_ch);
            else if (r < 9) line_q.push_back(neg_ch);
            else            line_q.push_back(filler_byte());
        end
    endtask

    task automatic add_fix(input string lat, input string ns, input string lon,
                           input string ew, input int n_commas);
        add_text("$GNRMC,,A,");
        add_text(lat);
        line_q.push_back(CH_COMMA);
        add_text(ns);
        line_q.push_back(CH_COMMA);
        add_text(lon);
        line_q.push_back(CH_COMMA);
        add_text(ew);
        repeat (n_commas - 6) line_q.push_back(CH_COMMA);
        line_q.push_back(CH_STAR);
    endtask

    // mostly well-formed sentences with random content, the rest broken
    task automatic random_sentence();
        int kind;
        int f;
        int lat_len;
        int lon_len;
        int ns_len;
        int ew_len;
        int n_commas;
        bit noisy;
        bit closed;
        kind     = $urandom_range(0, 15);
        lat_len  = LAT_LEN;
        lon_len  = LON_LEN;
        ns_len   = 1;
        ew_len   = 1;
        n_commas = COMMAS_OK;
        noisy    = ($urandom_range(0, 7) == 0);
        closed   = 1'b1;
        case (kind)
            10: lat_len = $urandom_range(0, 17);
            11: lon_len = $urandom_range(0, 17);
            12: begin
                ns_len = $urandom_range(0, 2);
                ew_len = $urandom_range(0, 2);
            end
            13: n_commas = $urandom_range(0, 17);
            14: closed = 1'b0;
            // raw noise ahead of the header, stars outside a frame included
            15: repeat ($urandom_range(1, 12)) line_q.push_back(BYTE_W'($urandom_range(0, 255)));
            default: ;
        endcase
        add_text("$GNR");
        for (f = 0; f <= n_commas; f++) begin
            case (f)
                0: begin
                    if ($urandom_range(0, 3) != 0) add_text("MC");
                    else add_filler($urandom_range(0, 3));
                end
                2: add_text("A");
                3: add_coord(lat_len, LAT_POINT, noisy);
                4: add_hemi(ns_len, CH_N, CH_S);
                5: add_coord(lon_len, LON_POINT, noisy);
                6: add_hemi(ew_len, CH_E, CH_W);
                default: add_filler($urandom_range(0, 4));
            endcase
            if (f < n_commas) line_q.push_back(CH_COMMA);
        end
        if (closed) line_q.push_back(CH_STAR);
        send_line();
    endtask

    // result side: random stalls, and one long hold when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (snk_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_fix("0000.00000", "N", "00000.00000", "E", COMMAS_OK);
        add_fix("9959.99999", "N", "17959.99999", "E", COMMAS_OK);
        add_fix("9999.99999", "S", "99999.99999", "W", COMMAS_OK);
        // lowercase hemisphere counts as negative, non-digits count as zero
        add_fix("4807.038x0", "n", "01131.0A000", "e", COMMAS_OK);
        add_fix("4807/03800", "N", "01131#00000", "E", COMMAS_OK);
        add_fix("4807.0380", "N", "01131.000000", "E", COMMAS_OK);
        add_fix("4807.03800123456", "S", "01131.00000", "W", COMMAS_OK);
        add_fix("4807.03800", "NS", "01131.00000", "", COMMAS_OK);
        add_fix("4807.03800", "N", "01131.00000", "E", COMMAS_OK - 1);
        add_fix("4807.03800", "N", "01131.00000", "E", COMMAS_OK + 1);
        add_fix("4807.03800", "N", "01131.00000", "E", 20);
        add_text("**x*$GNR*");
        // header inside an open frame restarts it
        add_text("$GNRMC,1,A,48");
        add_fix("4916.45000", "S", "12311.12000", "W", COMMAS_OK);
        add_text("$$G$GNR,,*");
        add_text("$GNRMC,");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        add_text(",*");
        // frame left open, then a fresh one
        add_text("$GNRMC,,A,1234");
        add_fix("0100.00001", "N", "00100.00002", "E", COMMAS_OK);
        send_line();

        // long receiver hold while short frames keep coming
        hold_start = 1'b1;
        repeat (30) add_text("$GNR,*");
        send_line();

        while (bytes_sent < ITEM_TARGET) begin
            src_idle = (bytes_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            snk_idle = (bytes_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            random_sentence();
        end
        s_tvalid <= 1'b0;

        while (fixes_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && fixes_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
